### hdl/gibm_pkg.sv
// Shared types, sizes and helpers for the greedy IoU box matcher.
// No dependencies; gibm_cell.sv and greedy_iou_box_matcher.sv import this package.
package gibm_pkg;

  localparam int MAX_TRACKS     = 32;
  localparam int MAX_DETECTIONS = 32;
  localparam int COORD_BITS     = 12;

  localparam int TI_W   = $clog2(MAX_TRACKS);
  localparam int DI_W   = $clog2(MAX_DETECTIONS);
  localparam int TC_W   = $clog2(MAX_TRACKS + 1);
  localparam int DC_W   = $clog2(MAX_DETECTIONS + 1);
  localparam int LBL_W  = 8;
  localparam int THR_W  = 16;
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int XP_W   = AREA_W + UNI_W;
  localparam int OIDX_W = 5;

  localparam logic [1:0] OP_LOAD_TRK = 2'd0;
  localparam logic [1:0] OP_LOAD_DET = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;

  localparam logic [1:0] KIND_MATCH   = 2'd0;
  localparam logic [1:0] KIND_UNM_TRK = 2'd1;
  localparam logic [1:0] KIND_UNM_DET = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    coord_t           x0;
    coord_t           y0;
    coord_t           x1;
    coord_t           y1;
  } dbox_t;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic             ended;
    logic             boxed;
    coord_t           x0;
    coord_t           y0;
    coord_t           x1;
    coord_t           y1;
  } tbox_t;

  typedef struct packed {
    logic              found;
    logic [TI_W-1:0]   tidx;
    logic [DI_W-1:0]   didx;
    logic [AREA_W-1:0] n;
    logic [UNI_W-1:0]  u;
  } cand_t;

  typedef struct packed {
    logic            ld;
    logic [TI_W-1:0] ld_idx;
    logic            take;
    logic [TI_W-1:0] take_idx;
    logic            clr_taken;
    logic            new_round;
  } cell_ctl_t;

  function automatic coord_t span(input coord_t lo, input coord_t hi);
    span = (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    cmax = (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    cmin = (a < b) ? a : b;
  endfunction

endpackage

### hdl/gibm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gibm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/gibm_cell.sv
// One track cell: holds a track box, scores broadcast detections against it,
// keeps its best pair and passes the running winner to its neighbor. Uses gibm_pkg.
module gibm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gibm_pkg::TI_W-1:0]   idx,
  input  logic                        used,
  input  gibm_pkg::cell_ctl_t         ctl,
  input  gibm_pkg::tbox_t             tbox,
  input  logic                        bvld,
  input  gibm_pkg::dbox_t             dbox,
  input  logic [gibm_pkg::DI_W-1:0]   didx,
  input  logic [gibm_pkg::THR_W-1:0]  thr,
  input  logic                        cin_vld,
  input  gibm_pkg::cand_t             cin,
  output logic                        cout_vld,
  output gibm_pkg::cand_t             cout,
  output logic                        taken
);
  import gibm_pkg::*;

  tbox_t             box_r;
  logic              taken_r;
  cand_t             best_r;

  logic              s1_vld_r;
  coord_t            tw_r, th_r, dw_r, dh_r, iw_r, ih_r;
  logic [DI_W-1:0]   s1_d_r;
  logic              s2_vld_r;
  logic [AREA_W-1:0] s2_i_r, s2_at_r, s2_ad_r;
  logic [DI_W-1:0]   s2_d_r;
  logic              s3_vld_r;
  logic [AREA_W-1:0] s3_i_r;
  logic [UNI_W-1:0]  s3_u_r;
  logic [DI_W-1:0]   s3_d_r;
  logic              s4_vld_r;
  logic [AREA_W-1:0] s4_i_r;
  logic [UNI_W-1:0]  s4_u_r;
  logic [THR_W+UNI_W-1:0] s4_tp_r;
  logic [DI_W-1:0]   s4_d_r;
  logic              s5_vld_r;
  logic [AREA_W-1:0] s5_i_r;
  logic [UNI_W-1:0]  s5_u_r;
  logic [XP_W-1:0]   s5_pa_r, s5_pb_r;
  logic [DI_W-1:0]   s5_d_r;

  logic              rin_vld_r;
  cand_t             rin_r;
  logic [XP_W-1:0]   ra_r, rb_r;
  logic              cout_vld_r;
  cand_t             cout_r;

  logic              elig;
  logic [UNI_W-1:0]  uni_nxt;

  assign elig = bvld && used && !taken_r && !box_r.ended && box_r.boxed &&
                (box_r.label == dbox.label);
  assign uni_nxt = UNI_W'(s2_at_r) + UNI_W'(s2_ad_r) - UNI_W'(s2_i_r);

  always_ff @(posedge clk) begin
    if (ctl.ld && ctl.ld_idx == idx) begin
      box_r <= tbox;
    end
    tw_r   <= span(box_r.x0, box_r.x1);
    th_r   <= span(box_r.y0, box_r.y1);
    dw_r   <= span(dbox.x0, dbox.x1);
    dh_r   <= span(dbox.y0, dbox.y1);
    iw_r   <= span(cmax(box_r.x0, dbox.x0), cmin(box_r.x1, dbox.x1));
    ih_r   <= span(cmax(box_r.y0, dbox.y0), cmin(box_r.y1, dbox.y1));
    s1_d_r <= didx;
    s2_i_r  <= AREA_W'(iw_r) * AREA_W'(ih_r);
    s2_at_r <= AREA_W'(tw_r) * AREA_W'(th_r);
    s2_ad_r <= AREA_W'(dw_r) * AREA_W'(dh_r);
    s2_d_r  <= s1_d_r;
    s3_i_r <= s2_i_r;
    s3_u_r <= uni_nxt;
    s3_d_r <= s2_d_r;
    s4_i_r  <= s3_i_r;
    s4_u_r  <= s3_u_r;
    s4_tp_r <= (THR_W+UNI_W)'(thr) * (THR_W+UNI_W)'(s3_u_r);
    s4_d_r  <= s3_d_r;
    s5_i_r  <= s4_i_r;
    s5_u_r  <= s4_u_r;
    // cross products against the best pair held before this candidate
    s5_pa_r <= XP_W'(s4_i_r) * XP_W'(best_r.u);
    s5_pb_r <= XP_W'(best_r.n) * XP_W'(s4_u_r);
    s5_d_r  <= s4_d_r;
    rin_r <= cin;
    ra_r  <= XP_W'(best_r.n) * XP_W'(cin.u);
    rb_r  <= XP_W'(cin.n) * XP_W'(best_r.u);
    if (rin_vld_r) begin
      // incoming winner comes from lower tracks, so it keeps ties
      cout_r <= (best_r.found && (!rin_r.found || ra_r > rb_r)) ? best_r : rin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r    <= 1'b0;
      best_r     <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      s5_vld_r   <= 1'b0;
      rin_vld_r  <= 1'b0;
      cout_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_taken) begin
        taken_r <= 1'b0;
      end else if (ctl.take && ctl.take_idx == idx) begin
        taken_r <= 1'b1;
      end
      s1_vld_r   <= elig;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r && (uni_nxt != '0);
      s4_vld_r   <= s3_vld_r;
      s5_vld_r   <= s4_vld_r &&
                    ((THR_W+UNI_W)'({s4_i_r, {THR_W{1'b0}}}) > s4_tp_r);
      rin_vld_r  <= cin_vld;
      cout_vld_r <= rin_vld_r;
      if (ctl.new_round) begin
        best_r.found <= 1'b0;
      end else if (s5_vld_r && (!best_r.found || s5_pa_r > s5_pb_r)) begin
        best_r <= '{found: 1'b1, tidx: idx, didx: s5_d_r, n: s5_i_r, u: s5_u_r};
      end
    end
  end

  assign cout_vld = cout_vld_r;
  assign cout     = cout_r;
  assign taken    = taken_r;
endmodule

### hdl/greedy_iou_box_matcher.sv
// Top level of the greedy IoU box matcher: controller, detection RAM and the
// row of track cells. Uses gibm_pkg, gibm_ram and gibm_cell.
//
// Usage: send items on the in_ stream. tuser holds the operation. Loads
// of tracks or detections into a full store are dropped. A run item starts
// the association: each round streams the stored detections past all track
// cells, spaced so that each best update lands before the next compare,
// waits for the scoring pipeline to drain, then passes the round winner
// down the cell chain; rounds repeat until no pair clears the threshold.
// Unmatched tracks and detections are then scanned one per cycle unless
// the output stalls. Results leave on the out_ stream, at most one per
// cycle, with tlast on the final one of the run.
// in_tready is low from the run item until the last result has been handed
// to the output register; a stalled receiver simply holds the block.
// cfg_ writes set the IoU threshold and are always taken.
// Reset (rst_n low, synchronous) empties both stores, clears all match
// marks and sets the threshold to one half.
module greedy_iou_box_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] label, [8] track_ended, [9] has_box, [21:10] x_left,
  // [33:22] y_top, [45:34] x_right, [57:46] y_bottom, rest zero
  input  logic [63:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] track_index, [9:5] detection_index, rest zero
  output logic [15:0] out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import gibm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_TLIST  = 3'd5;
  localparam logic [2:0] S_DLIST  = 3'd6;
  localparam logic [2:0] S_FLUSH  = 3'd7;
  localparam logic [3:0] DRAIN_CYC = 4'd9;

  logic [2:0]          state_r, state_nxt;
  logic [THR_W-1:0]    thr_r;
  logic [TC_W-1:0]     tc_r;
  logic [DC_W-1:0]     dc_r;
  logic [DC_W-1:0]     jc_r;
  logic                ph_r;
  logic [3:0]          drain_r;
  logic [TC_W-1:0]     tscan_r;
  logic [DC_W-1:0]     dscan_r;
  logic [MAX_DETECTIONS-1:0] det_taken_r;
  logic                issue_q_r;
  logic [DI_W-1:0]     didx_q_r;
  logic                go_r;
  cand_t               win_r;

  logic                pend_vld_r;
  logic [1:0]          pend_kind_r;
  logic [TI_W-1:0]     pend_t_r;
  logic [DI_W-1:0]     pend_d_r;
  logic                out_vld_r;
  logic [1:0]          out_kind_r;
  logic [TI_W-1:0]     out_t_r;
  logic [DI_W-1:0]     out_d_r;
  logic                out_last_r;

  logic                in_acc, out_free, can_push, flush_en;
  logic                push_en;
  logic [1:0]          push_kind;
  logic [TI_W-1:0]     push_t;
  logic [DI_W-1:0]     push_d;
  logic                issue;
  logic                det_we;
  dbox_t               det_wdata, det_rdata;
  tbox_t               tbox;
  cell_ctl_t           ctl;
  logic [MAX_TRACKS-1:0] used, trk_taken;
  logic [MAX_TRACKS:0]   chain_vld;
  cand_t               chain [MAX_TRACKS+1];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign tbox = '{label: in_tdata[7:0], ended: in_tdata[8], boxed: in_tdata[9],
                  x0: in_tdata[21:10], y0: in_tdata[33:22],
                  x1: in_tdata[45:34], y1: in_tdata[57:46]};
  assign det_wdata = '{label: in_tdata[7:0], x0: in_tdata[21:10], y0: in_tdata[33:22],
                       x1: in_tdata[45:34], y1: in_tdata[57:46]};
  assign det_we = in_acc && in_tuser == OP_LOAD_DET && dc_r < DC_W'(MAX_DETECTIONS);

  gibm_ram #(.WIDTH($bits(dbox_t)), .DEPTH(MAX_DETECTIONS)) u_det_ram (
    .clk   (clk),
    .we    (det_we),
    .waddr (dc_r[DI_W-1:0]),
    .wdata (det_wdata),
    .raddr (jc_r[DI_W-1:0]),
    .rdata (det_rdata)
  );

  assign issue    = (state_r == S_SWEEP) && (jc_r != dc_r) && !ph_r;
  assign out_free = !out_vld_r || out_tready;
  assign can_push = !pend_vld_r || out_free;
  assign flush_en = (state_r == S_FLUSH) && pend_vld_r && out_free;

  always_comb begin
    state_nxt     = state_r;
    push_en       = 1'b0;
    push_kind     = KIND_MATCH;
    push_t        = '0;
    push_d        = '0;
    ctl.ld        = in_acc && in_tuser == OP_LOAD_TRK && tc_r < TC_W'(MAX_TRACKS);
    ctl.ld_idx    = tc_r[TI_W-1:0];
    ctl.take      = 1'b0;
    ctl.take_idx  = win_r.tidx;
    ctl.clr_taken = 1'b0;
    ctl.new_round = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OP_RUN) begin
          state_nxt     = S_SWEEP;
          ctl.new_round = 1'b1;
        end
      end
      S_SWEEP: begin
        if (jc_r == dc_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_r == DRAIN_CYC) begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (chain_vld[MAX_TRACKS]) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!win_r.found) begin
          state_nxt = S_TLIST;
        end else if (can_push) begin
          push_en       = 1'b1;
          push_t        = win_r.tidx;
          push_d        = win_r.didx;
          ctl.take      = 1'b1;
          ctl.new_round = 1'b1;
          state_nxt     = S_SWEEP;
        end
      end
      S_TLIST: begin
        if (tscan_r == tc_r) begin
          state_nxt = S_DLIST;
        end else if (!trk_taken[tscan_r[TI_W-1:0]]) begin
          push_en   = can_push;
          push_kind = KIND_UNM_TRK;
          push_t    = tscan_r[TI_W-1:0];
        end
      end
      S_DLIST: begin
        if (dscan_r == dc_r) begin
          state_nxt = S_FLUSH;
        end else if (!det_taken_r[dscan_r[DI_W-1:0]]) begin
          push_en   = can_push;
          push_kind = KIND_UNM_DET;
          push_d    = dscan_r[DI_W-1:0];
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt     = S_IDLE;
          ctl.clr_taken = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    didx_q_r <= jc_r[DI_W-1:0];
    if (state_r == S_REDUCE && chain_vld[MAX_TRACKS]) begin
      win_r <= chain[MAX_TRACKS];
    end
    if (push_en) begin
      pend_kind_r <= push_kind;
      pend_t_r    <= push_t;
      pend_d_r    <= push_d;
    end
    if ((push_en && pend_vld_r) || flush_en) begin
      out_kind_r <= pend_kind_r;
      out_t_r    <= pend_t_r;
      out_d_r    <= pend_d_r;
      out_last_r <= flush_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_W'(32768);
      tc_r        <= '0;
      dc_r        <= '0;
      jc_r        <= '0;
      ph_r        <= 1'b0;
      drain_r     <= '0;
      tscan_r     <= '0;
      dscan_r     <= '0;
      det_taken_r <= '0;
      issue_q_r   <= 1'b0;
      go_r        <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      issue_q_r <= issue;
      go_r      <= (state_r == S_DRAIN) && (state_nxt == S_REDUCE);
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (ctl.ld) begin
        tc_r <= tc_r + 1'b1;
      end
      if (det_we) begin
        dc_r <= dc_r + 1'b1;
      end
      // the phase bit ph_r spaces the detections so each best update lands before the next compare
      if (ctl.new_round) begin
        jc_r <= '0;
        ph_r <= 1'b0;
      end else if (state_r == S_SWEEP && jc_r != dc_r) begin
        ph_r <= !ph_r;
        if (ph_r) begin
          jc_r <= jc_r + 1'b1;
        end
      end
      drain_r <= (state_r == S_DRAIN) ? drain_r + 1'b1 : '0;
      if (ctl.take) begin
        det_taken_r[win_r.didx] <= 1'b1;
      end
      if (state_r == S_TLIST && tscan_r != tc_r &&
          (trk_taken[tscan_r[TI_W-1:0]] || can_push)) begin
        tscan_r <= tscan_r + 1'b1;
      end
      if (state_r == S_DLIST && dscan_r != dc_r &&
          (det_taken_r[dscan_r[DI_W-1:0]] || can_push)) begin
        dscan_r <= dscan_r + 1'b1;
      end
      if (ctl.clr_taken) begin
        tc_r        <= '0;
        dc_r        <= '0;
        tscan_r     <= '0;
        dscan_r     <= '0;
        det_taken_r <= '0;
      end
      if (push_en) begin
        pend_vld_r <= 1'b1;
      end else if (flush_en) begin
        pend_vld_r <= 1'b0;
      end
      if ((push_en && pend_vld_r) || flush_en) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign chain[0]     = '0;
  assign chain_vld[0] = go_r;

  for (genvar k = 0; k < MAX_TRACKS; k++) begin : g_cell
    assign used[k] = TC_W'(k) < tc_r;
    gibm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (TI_W'(k)),
      .used     (used[k]),
      .ctl      (ctl),
      .tbox     (tbox),
      .bvld     (issue_q_r && !det_taken_r[didx_q_r]),
      .dbox     (det_rdata),
      .didx     (didx_q_r),
      .thr      (thr_r),
      .cin_vld  (chain_vld[k]),
      .cin      (chain[k]),
      .cout_vld (chain_vld[k+1]),
      .cout     (chain[k+1]),
      .taken    (trk_taken[k])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, OIDX_W'(out_d_r), OIDX_W'(out_t_r)};

  a_chain_in_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[MAX_TRACKS] |-> state_r == S_REDUCE)
    else $error("cell chain result outside reduce phase");

  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && win_r.found) |-> !det_taken_r[win_r.didx])
    else $error("round winner uses a detection already matched");

  a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_vld_r)
    else $error("pending result left behind at idle");

endmodule

### test/tb_greedy_iou_box_matcher.sv
// Testbench for the greedy IoU box matcher: drives box loads and runs on the
// in_ stream, predicts the match/unmatched reports and checks the out_ stream.
// Depends on gibm_pkg and the greedy_iou_box_matcher RTL.
module tb_greedy_iou_box_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import gibm_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [4:0] trk;
    logic [4:0] det;
    logic       last;
  } report_t;

  typedef struct {
    logic [7:0]  label;
    logic        ended;
    logic        boxed;
    logic [11:0] x0, y0, x1, y1;
  } box_t;

  int errors = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  class match_scoreboard;
    box_t        trk[$];
    box_t        det[$];
    logic [15:0] threshold = 16'd32768;
    report_t     pending[$];

    function automatic longint unsigned span12(logic [11:0] lo, logic [11:0] hi);
      return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    function automatic void areas(box_t a, box_t b, output longint unsigned inter,
                                  output longint unsigned uni);
      longint unsigned aa, ab;
      aa = span12(a.x0, a.x1) * span12(a.y0, a.y1);
      ab = span12(b.x0, b.x1) * span12(b.y0, b.y1);
      inter = span12(a.x0 > b.x0 ? a.x0 : b.x0, a.x1 < b.x1 ? a.x1 : b.x1) *
              span12(a.y0 > b.y0 ? a.y0 : b.y0, a.y1 < b.y1 ? a.y1 : b.y1);
      uni = aa + ab - inter;
    endfunction

    function automatic void note_request(logic [1:0] op, box_t b);
      bit tt[32], dt[32];
      report_t r[$];
      report_t rr;
      if (op == OP_LOAD_TRK) begin
        if (trk.size() < MAX_TRACKS) trk = {trk, b};
      end else if (op == OP_LOAD_DET) begin
        if (det.size() < MAX_DETECTIONS) det = {det, b};
      end else if (op == OP_RUN) begin
        forever begin
          bit found = 0;
          int bt = 0, bd = 0;
          longint unsigned bn = 0, bu = 1, inter, uni;
          for (int i = 0; i < trk.size(); i++) begin
            if (tt[i] || trk[i].ended || !trk[i].boxed) continue;
            for (int j = 0; j < det.size(); j++) begin
              if (dt[j] || det[j].label != trk[i].label) continue;
              areas(trk[i], det[j], inter, uni);
              if (uni == 0) continue;
              if (!(inter * 65536 > longint'(threshold) * uni)) continue;
              // areas fit in 25 bits, so the cross products fit in 64
              if (!found || inter * bu > bn * uni) begin
                found = 1; bt = i; bd = j; bn = inter; bu = uni;
              end
            end
          end
          if (!found) break;
          tt[bt] = 1; dt[bd] = 1;
          rr = '{KIND_MATCH, bt[4:0], bd[4:0], 1'b0}; r = {r, rr};
        end
        for (int i = 0; i < trk.size(); i++)
          if (!tt[i]) begin rr = '{KIND_UNM_TRK, i[4:0], 5'd0, 1'b0}; r = {r, rr}; end
        for (int j = 0; j < det.size(); j++)
          if (!dt[j]) begin rr = '{KIND_UNM_DET, 5'd0, j[4:0], 1'b0}; r = {r, rr}; end
        if (r.size() > 0) r[r.size()-1].last = 1;
        pending = {pending, r};
        trk.delete();
        det.delete();
      end
    endfunction

    task check_result(logic [1:0] kind, logic [15:0] data, logic last);
      report_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %h", kind, data));
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind || data[4:0] !== e.trk || data[9:5] !== e.det ||
          data[15:10] !== 6'd0 || last !== e.last)
        report_mismatch($sformatf("got k%0d t%0d d%0d l%0d, want k%0d t%0d d%0d l%0d",
                                  kind, data[4:0], data[9:5], last,
                                  e.kind, e.trk, e.det, e.last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid, out_tready = 0, out_tlast;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 0, cfg_ready;
  logic [15:0] cfg_data = '0;

  match_scoreboard sb = new();
  int  idle_pct = 32;
  bit  rx_hold = 0;
  int  sent = 0;

  always #6 clk = ~clk;

  greedy_iou_box_matcher DUT (.*);

  // receiver: random backpressure, plus an occasional long hold
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata, out_tlast);
    out_tready <= !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  task automatic send(input logic [1:0] op, input box_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, b.y1, b.x1, b.y0, b.x0, b.boxed, b.ended, b.label};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, b);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 || !in_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.threshold = v;
  endtask

  function automatic box_t rand_box(input int lbl_range);
    box_t b;
    int w;
    b.label = 8'($urandom_range(lbl_range));
    b.ended = ($urandom_range(9) == 0);
    b.boxed = ($urandom_range(9) != 0);
    b.x0 = 12'($urandom_range(4095 - 600));
    b.y0 = 12'($urandom_range(4095 - 600));
    w = $urandom_range(600);
    b.x1 = b.x0 + 12'(w);
    b.y1 = b.y0 + 12'($urandom_range(600));
    if ($urandom_range(19) == 0) b.x1 = 12'($urandom);  // may be reversed
    if ($urandom_range(19) == 0) b.y1 = 12'($urandom);
    return b;
  endfunction

  function automatic box_t jitter(input box_t b);
    box_t j = b;
    j.ended = 0;
    j.boxed = 1;
    j.x0 = b.x0 + 12'($urandom_range(20));
    j.y0 = b.y0 + 12'($urandom_range(20));
    j.x1 = b.x1 + 12'($urandom_range(20));
    j.y1 = b.y1 + 12'($urandom_range(20));
    return j;
  endfunction

  box_t bx, tr[$];
  box_t z = '{8'd0, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: full extremes, zero area, reversed, ended, no box, empty run
    send(OP_RUN, z);
    bx = '{8'hFF, 1'b0, 1'b1, 12'd0, 12'd0, 12'hFFF, 12'hFFF};
    send(OP_LOAD_TRK, bx);
    send(OP_LOAD_DET, bx);
    bx.ended = 1; send(OP_LOAD_TRK, bx);
    bx.ended = 0; bx.boxed = 0; send(OP_LOAD_TRK, bx);
    bx = '{8'd0, 1'b0, 1'b1, 12'd5, 12'd5, 12'd5, 12'd5};
    send(OP_LOAD_TRK, bx);
    send(OP_LOAD_DET, bx);
    bx = '{8'd1, 1'b0, 1'b1, 12'hFFF, 12'hFFF, 12'd0, 12'd0};
    send(OP_LOAD_TRK, bx);
    send(OP_LOAD_DET, bx);
    send(OP_UNKNOWN, bx);
    send(OP_RUN, z);
    wait_drained();
    // overfill both stores with identical boxes, so every round is a tie
    for (int i = 0; i < 66; i++) begin
      bx = '{8'd3, 1'b0, 1'b1, 12'd10, 12'd10, 12'd50, 12'd50};
      send(i % 2 ? OP_LOAD_DET : OP_LOAD_TRK, bx);
    end
    send(OP_RUN, z);
    wait_drained();

    // random phases across thresholds, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      logic [15:0] thr;
      case (ph)
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'd32768;
        default: thr = 16'($urandom);
      endcase
      write_threshold(thr);
      idle_pct = (ph == 3) ? 0 : 32;
      for (int run = 0; run < 3; run++) begin
        int nt, nd, lr;
        nt = $urandom_range(6);
        nd = $urandom_range(6);
        lr = $urandom_range(3);
        if (ph == 5 && run == 0) begin
          nt = 8;
          nd = 8;
        end
        tr.delete();
        for (int i = 0; i < nt; i++) begin
          bx = rand_box(lr); tr = {tr, bx}; send(OP_LOAD_TRK, bx);
        end
        for (int j = 0; j < nd; j++) begin
          if (tr.size() > 0 && $urandom_range(3) != 0)
            bx = jitter(tr[$urandom_range(tr.size() - 1)]);
          else
            bx = rand_box(lr);
          send(OP_LOAD_DET, bx);
        end
        if ($urandom_range(9) == 0) send(OP_UNKNOWN, rand_box(255));
        if (ph == 5 && run == 0) begin
          // hold off the receiver while the next loads keep coming
          fork
            begin
              rx_hold = 1;
              repeat (1000) @(posedge clk);
              rx_hold = 0;
            end
          join_none
        end
        send(OP_RUN, z);
      end
      if (ph == 5) begin
        for (int i = 0; i < 3; i++) send(OP_LOAD_TRK, rand_box(0));
        send(OP_RUN, z);
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
